// ===== rtl/vcl_pkg.sv =====
// shared constants and types for the velocity command line parser
`timescale 1ns / 1ps
`default_nettype none

package vcl_pkg;

   // line buffer limit: a line restarts when it reaches LINE_CAP - 1 bytes
   localparam int LINE_CAP = 64;
   localparam int LEN_W    = $clog2(LINE_CAP);
   localparam int SPEED_W  = 16;

   // parsed command handed from the parser to the result stage
   typedef struct packed {
      logic               valid;
      logic [SPEED_W-1:0] linear;
      logic [SPEED_W-1:0] angular;
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/vcl_parser.sv =====
// per-byte parse state machine for V:<int>,W:<int> command lines
`timescale 1ns / 1ps
`default_nettype none

module vcl_parser
   import vcl_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       byte_valid,
   input  wire logic [7:0] rx_byte,
   output cmd_type         cmd
);

   typedef enum logic [3:0] {
      PH_V    = 4'd0,
      PH_C1   = 4'd1,
      PH_VWS  = 4'd2,
      PH_VNUM = 4'd3,
      PH_W    = 4'd4,
      PH_C2   = 4'd5,
      PH_WWS  = 4'd6,
      PH_WNUM = 4'd7,
      PH_DONE = 4'd8,
      PH_FAIL = 4'd9
   } phase_type;

   localparam logic [7:0] CH_V     = 8'h56;
   localparam logic [7:0] CH_W     = 8'h57;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_VT    = 8'h0b;
   localparam logic [7:0] CH_FF    = 8'h0c;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [16:0] MAG_SAT = 17'd32768;

   phase_type          phase_ff, phase_in;
   logic [LEN_W-1:0]   len_ff, len_in, len_next;
   logic               neg_ff, neg_in;
   logic               digit_ff, digit_in;
   logic [SPEED_W-1:0] linear_ff, linear_in;
   logic [SPEED_W-1:0] angular_ff, angular_in;
   logic [16:0]        acc_ff, acc_in;
   logic               is_term, is_space, is_digit, is_sign;

   function automatic logic [16:0] add_digit(input logic [16:0] acc, input logic [3:0] dig);
      logic [20:0] m;
      m = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {17'd0, dig};
      add_digit = (m > {4'd0, MAG_SAT}) ? MAG_SAT : m[16:0];
   endfunction

   // two's complement value of the number read so far, clamped on the positive side
   function automatic logic [SPEED_W-1:0] number_value(input logic neg, input logic [16:0] acc);
      logic [15:0] d;
      d = 16'd0 - acc[15:0];
      if (neg) begin
         number_value = d;
      end else begin
         number_value = (acc > 17'd32767) ? 16'h7fff : acc[15:0];
      end
   endfunction

   assign is_term  = (rx_byte == CH_LF) || (rx_byte == CH_CR);
   assign is_space = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB) ||
                     (rx_byte == CH_VT) || (rx_byte == CH_FF);
   assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
   assign is_sign  = (rx_byte == CH_PLUS) || (rx_byte == CH_MINUS);
   assign len_next = len_ff + LEN_W'(1);

   always_comb begin
      phase_in   = phase_ff;
      len_in     = len_ff;
      neg_in     = neg_ff;
      digit_in   = digit_ff;
      linear_in  = linear_ff;
      angular_in = angular_ff;
      acc_in     = acc_ff;
      cmd        = '0;
      if (byte_valid) begin
         if (is_term) begin
            if (len_ff != '0) begin
               cmd.valid   = (phase_ff == PH_DONE);
               cmd.linear  = linear_ff;
               cmd.angular = angular_ff;
               // a terminator right after W digits closes the number
               if (phase_ff == PH_WNUM && digit_ff) begin
                  cmd.valid   = 1'b1;
                  cmd.angular = number_value(neg_ff, acc_ff);
               end
               phase_in   = PH_V;
               len_in     = '0;
               neg_in     = 1'b0;
               digit_in   = 1'b0;
               linear_in  = '0;
               angular_in = '0;
               acc_in     = '0;
            end
         end else begin
            unique case (phase_ff)
               PH_V:  phase_in = (rx_byte == CH_V) ? PH_C1 : PH_FAIL;
               PH_C1: phase_in = (rx_byte == CH_COLON) ? PH_VWS : PH_FAIL;
               PH_W:  phase_in = (rx_byte == CH_W) ? PH_C2 : PH_FAIL;
               PH_C2: phase_in = (rx_byte == CH_COLON) ? PH_WWS : PH_FAIL;
               PH_VWS, PH_WWS: begin
                  neg_in   = 1'b0;
                  digit_in = 1'b0;
                  acc_in   = '0;
                  if (is_space) begin
                     phase_in = phase_ff;
                  end else if (is_sign) begin
                     neg_in   = (rx_byte == CH_MINUS);
                     phase_in = (phase_ff == PH_VWS) ? PH_VNUM : PH_WNUM;
                  end else if (is_digit) begin
                     acc_in   = add_digit('0, rx_byte[3:0]);
                     digit_in = 1'b1;
                     phase_in = (phase_ff == PH_VWS) ? PH_VNUM : PH_WNUM;
                  end else begin
                     phase_in = PH_FAIL;
                  end
               end
               PH_VNUM: begin
                  if (is_digit) begin
                     acc_in   = add_digit(acc_ff, rx_byte[3:0]);
                     digit_in = 1'b1;
                  end else if (digit_ff && rx_byte == CH_COMMA) begin
                     linear_in = number_value(neg_ff, acc_ff);
                     phase_in  = PH_W;
                  end else begin
                     phase_in = PH_FAIL;
                  end
               end
               PH_WNUM: begin
                  if (is_digit) begin
                     acc_in   = add_digit(acc_ff, rx_byte[3:0]);
                     digit_in = 1'b1;
                  end else if (digit_ff) begin
                     angular_in = number_value(neg_ff, acc_ff);
                     phase_in   = PH_DONE;
                  end else begin
                     phase_in = PH_FAIL;
                  end
               end
               PH_DONE: phase_in = PH_DONE;
               default: phase_in = PH_FAIL;
            endcase
            // overlong line drops everything read so far
            if (len_next >= LEN_W'(LINE_CAP - 1)) begin
               phase_in   = PH_V;
               len_in     = '0;
               neg_in     = 1'b0;
               digit_in   = 1'b0;
               linear_in  = '0;
               angular_in = '0;
               acc_in     = '0;
            end else begin
               len_in = len_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_V;
         len_ff     <= '0;
         neg_ff     <= 1'b0;
         digit_ff   <= 1'b0;
         linear_ff  <= '0;
         angular_ff <= '0;
         acc_ff     <= '0;
      end else begin
         phase_ff   <= phase_in;
         len_ff     <= len_in;
         neg_ff     <= neg_in;
         digit_ff   <= digit_in;
         linear_ff  <= linear_in;
         angular_ff <= angular_in;
         acc_ff     <= acc_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/vcl_result.sv =====
// wheel speed mix and result register
`timescale 1ns / 1ps
`default_nettype none

module vcl_result
   import vcl_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cmd_type              cmd,
   input  wire logic                 take,
   output logic                      out_valid,
   output logic [SPEED_W-1:0]        left_wheel,
   output logic [SPEED_W-1:0]        right_wheel
);

   logic               valid_ff, valid_in;
   logic [SPEED_W-1:0] left_ff, right_ff;
   logic [SPEED_W:0]   w_adj;
   logic [SPEED_W-1:0] half;

   // w / 2 rounded toward zero: add one before the shift when negative
   assign w_adj = {cmd.angular[SPEED_W-1], cmd.angular} +
                  {{SPEED_W{1'b0}}, cmd.angular[SPEED_W-1]};
   assign half  = w_adj[SPEED_W:1];

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b0;
      end
      if (cmd.valid) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.valid) begin
         left_ff  <= cmd.linear - half;
         right_ff <= cmd.linear + half;
      end
   end

   assign out_valid   = valid_ff;
   assign left_wheel  = left_ff;
   assign right_wheel = right_ff;

endmodule

`default_nettype wire

// ===== rtl/velocity_command_line_parser.sv =====
// top level: byte input register, command parser and speed result register
//
// channel  direction  tdata bits                               tuser/tlast
// req_     in         [7:0] rx_byte                            none
// rsp_     out        [15:0] left_wheel, [31:16] right_wheel   none
//
// one byte per cycle sustained while results are taken; rsp_tvalid follows the req transfer
// (input register, then parser and mix into the result register)
// a byte that completes a good line yields one rsp transfer, other bytes none
// synchronous active-high reset returns the parser to the start of a line
// a held result only blocks the input register; one more byte waits there
`timescale 1ns / 1ps
`default_nettype none

module velocity_command_line_parser
   import vcl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata    // [15:0] left_wheel, [31:16] right_wheel
);

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_byte_ff;
   logic               advance;
   cmd_type            cmd;
   logic [SPEED_W-1:0] left_wheel, right_wheel;

   // the parser consumes the held byte once the result slot is free or draining
   assign advance     = in_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   vcl_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (advance),
      .rx_byte    (in_byte_ff),
      .cmd        (cmd)
   );

   vcl_result u_result (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .take        (rsp_tready),
      .out_valid   (rsp_tvalid),
      .left_wheel  (left_wheel),
      .right_wheel (right_wheel)
   );

   assign rsp_tdata = {right_wheel, left_wheel};

   // a finished command only appears while a byte is being consumed
   assert property (@(posedge clock) disable iff (reset) cmd.valid |-> advance)
      else $error("command produced without a consumed byte");

   // a finished command reaches the result register on the next edge
   assert property (@(posedge clock) disable iff (reset) cmd.valid |=> rsp_tvalid)
      else $error("command lost before the result register");

   // an empty input register always takes a transfer
   assert property (@(posedge clock) disable iff (reset) !in_valid_ff |-> req_tready)
      else $error("input stalled while empty");

   // a held result that is not taken keeps the parser still
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !advance)
      else $error("parser advanced over a pending result");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking bench for the velocity command line parser: text lines in, wheel speeds out
`timescale 1ns / 1ps

module testbench;
   import vcl_pkg::*;

   typedef logic [7:0] byte_type;

   typedef enum logic [3:0] {
      ST_V, ST_VCOLON, ST_VSPACE, ST_VDIGITS,
      ST_W, ST_WCOLON, ST_WSPACE, ST_WDIGITS,
      ST_ACCEPTED, ST_REJECTED
   } cmd_phase_type;

   typedef struct {
      logic [SPEED_W-1:0] left;
      logic [SPEED_W-1:0] right;
   } speed_pair_type;

   localparam byte_type CH_NUL   = 8'h00;
   localparam byte_type CH_TAB   = 8'h09;
   localparam byte_type CH_LF    = 8'h0A;
   localparam byte_type CH_VT    = 8'h0B;
   localparam byte_type CH_FF    = 8'h0C;
   localparam byte_type CH_CR    = 8'h0D;
   localparam byte_type CH_SPACE = 8'h20;
   localparam byte_type CH_PLUS  = 8'h2B;
   localparam byte_type CH_COMMA = 8'h2C;
   localparam byte_type CH_MINUS = 8'h2D;
   localparam byte_type CH_ZERO  = 8'h30;
   localparam byte_type CH_NINE  = 8'h39;
   localparam byte_type CH_COLON = 8'h3A;
   localparam byte_type CH_V     = 8'h56;
   localparam byte_type CH_W     = 8'h57;
   localparam byte_type CH_HIGH  = 8'hFF;

   localparam int MAG_SAT      = 32768;
   localparam int RANDOM_BYTES = 460;
   localparam int MAX_REPORTS  = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;           // [15:0] left_wheel, [31:16] right_wheel

   velocity_command_line_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // parser state as predicted
   cmd_phase_type      cmd_phase;
   int                 line_len;
   logic               num_negative;
   logic               digit_seen;
   logic [SPEED_W-1:0] linear;
   logic [SPEED_W-1:0] angular;
   int                 num_magnitude;

   speed_pair_type speed_queue[$];
   byte_type       line_buf[$];
   int             error_count    = 0;
   int             bytes_accepted = 0;
   int             lines_accepted = 0;
   int             idle_pct       = 0;
   int             stall_pct      = 0;

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_REPORTS)
         $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic void restart_command();
      cmd_phase     = ST_V;
      line_len      = 0;
      num_negative  = 1'b0;
      digit_seen    = 1'b0;
      linear        = '0;
      angular       = '0;
      num_magnitude = 0;
   endfunction

   function automatic logic is_space(input byte_type c);
      return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF;
   endfunction

   function automatic logic is_digit(input byte_type c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   // negative magnitudes wrap, positive ones clip at the int16 maximum
   function automatic logic [SPEED_W-1:0] parsed_number();
      if (num_negative)
         return 16'(65536 - num_magnitude);
      return (num_magnitude > 32767) ? 16'd32767 : 16'(num_magnitude);
   endfunction

   function automatic void add_digit(input byte_type c);
      int m;
      m = num_magnitude * 10 + (int'(c) - int'(CH_ZERO));
      num_magnitude = (m > MAG_SAT) ? MAG_SAT : m;
      digit_seen = 1'b1;
   endfunction

   function automatic cmd_phase_type number_start(input byte_type c,
                                                  input cmd_phase_type digits,
                                                  input cmd_phase_type here);
      num_negative  = 1'b0;
      digit_seen    = 1'b0;
      num_magnitude = 0;
      if (is_space(c))
         return here;
      if (c == CH_PLUS || c == CH_MINUS) begin
         num_negative = (c == CH_MINUS);
         return digits;
      end
      if (is_digit(c)) begin
         add_digit(c);
         return digits;
      end
      return ST_REJECTED;
   endfunction

   task automatic predict_rx_byte(input byte_type c);
      int             v, w, half;
      logic           ok;
      speed_pair_type pair;
      if (c == CH_LF || c == CH_CR) begin
         if (line_len != 0) begin
            if (cmd_phase == ST_WDIGITS && digit_seen) begin
               angular   = parsed_number();
               cmd_phase = ST_ACCEPTED;
            end
            ok = (cmd_phase == ST_ACCEPTED);
            v  = int'($signed(linear));
            w  = int'($signed(angular));
            restart_command();
            if (ok) begin
               half       = w / 2;
               pair.left  = 16'(v - half);
               pair.right = 16'(v + half);
               speed_queue.push_back(pair);
               lines_accepted++;
            end
         end
      end else begin
         case (cmd_phase)
            ST_V:       cmd_phase = (c == CH_V) ? ST_VCOLON : ST_REJECTED;
            ST_VCOLON:  cmd_phase = (c == CH_COLON) ? ST_VSPACE : ST_REJECTED;
            ST_VSPACE:  cmd_phase = number_start(c, ST_VDIGITS, ST_VSPACE);
            ST_VDIGITS: begin
               if (is_digit(c))
                  add_digit(c);
               else if (digit_seen && c == CH_COMMA) begin
                  linear    = parsed_number();
                  cmd_phase = ST_W;
               end else
                  cmd_phase = ST_REJECTED;
            end
            ST_W:       cmd_phase = (c == CH_W) ? ST_WCOLON : ST_REJECTED;
            ST_WCOLON:  cmd_phase = (c == CH_COLON) ? ST_WSPACE : ST_REJECTED;
            ST_WSPACE:  cmd_phase = number_start(c, ST_WDIGITS, ST_WSPACE);
            ST_WDIGITS: begin
               if (is_digit(c))
                  add_digit(c);
               else if (digit_seen) begin
                  angular   = parsed_number();
                  cmd_phase = ST_ACCEPTED;
               end else
                  cmd_phase = ST_REJECTED;
            end
            ST_ACCEPTED: ;
            default:    cmd_phase = ST_REJECTED;
         endcase
         line_len++;
         // overlong line: everything so far is dropped
         if (line_len >= LINE_CAP - 1)
            restart_command();
      end
   endtask

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_rx_byte(input byte_type b);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      predict_rx_byte(b);
      bytes_accepted++;
      @(negedge clock);
   endtask

   function automatic void put_byte(input byte_type b);
      line_buf.push_back(b);
   endfunction

   function automatic void put_text(input string s);
      for (int i = 0; i < s.len(); i++)
         line_buf.push_back(byte_type'(s[i]));
   endfunction

   task automatic flush_line();
      while (line_buf.size() != 0)
         send_rx_byte(line_buf.pop_front());
   endtask

   function automatic byte_type junk_byte();
      byte_type b;
      do b = byte_type'($urandom_range(255)); while (b == CH_LF || b == CH_CR);
      return b;
   endfunction

   function automatic void put_terminator();
      case ($urandom_range(2))
         0: put_byte(CH_LF);
         1: put_byte(CH_CR);
         default: begin
            // the second byte makes an empty line
            put_byte(CH_CR);
            put_byte(CH_LF);
         end
      endcase
   endfunction

   function automatic void put_number();
      byte_type ws[4];
      int       pick, mag;
      string    digits;
      ws = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};
      repeat ($urandom_range(3) == 0 ? $urandom_range(1, 2) : 0)
         put_byte(ws[$urandom_range(3)]);
      case ($urandom_range(2))
         1: put_byte(CH_PLUS);
         2: put_byte(CH_MINUS);
         default: ;
      endcase
      pick = $urandom_range(99);
      if (pick < 30)
         mag = $urandom_range(99);
      else if (pick < 70)
         mag = $urandom_range(32767);
      else if (pick < 85)
         mag = 32760 + $urandom_range(15);
      else
         mag = $urandom_range(999999);
      digits = $sformatf("%0d", mag);
      if ($urandom_range(9) == 0)
         digits = {"00", digits};
      put_text(digits);
   endfunction

   function automatic void put_command();
      put_text("V:");
      put_number();
      put_text(",W:");
      put_number();
   endfunction

   task automatic set_idling(input int sender, input int receiver);
      idle_pct  = sender;
      stall_pct = receiver;
   endtask

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      speed_pair_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (speed_queue.size() == 0)
            report_mismatch($sformatf("unexpected result %h", rsp_tdata));
         else begin
            want = speed_queue.pop_front();
            if (rsp_tdata[15:0] !== want.left)
               report_mismatch($sformatf("left wheel %h, want %h", rsp_tdata[15:0], want.left));
            if (rsp_tdata[31:16] !== want.right)
               report_mismatch($sformatf("right wheel %h, want %h",
                                         rsp_tdata[31:16], want.right));
         end
      end
   end

   task automatic test_good_lines();
      set_idling(0, 0);
      put_text("V:0,W:0");
      put_byte(CH_LF);
      put_text("V:32767,W:-32768");
      put_byte(CH_CR);
      put_text("V:-32768,W:32767");
      put_byte(CH_LF);
      put_text("V: ");
      put_byte(CH_TAB);
      put_text("+12,W:");
      put_byte(CH_VT);
      put_byte(CH_FF);
      put_text("-7 rest");
      put_byte(CH_CR);
      put_byte(CH_LF);
      // a high byte after the W digits is ignored
      put_text("V:1,W:3");
      put_byte(CH_HIGH);
      put_byte(CH_LF);
      flush_line();
   endtask

   task automatic test_rejected_lines();
      set_idling(14, 14);
      put_text("V:-,W:5");
      put_byte(CH_LF);
      put_byte(8'h80);
      put_text("V:1,W:1");
      put_byte(CH_LF);
      put_text("V:1,W:");
      put_byte(CH_CR);
      put_text("V:2W:4");
      put_byte(CH_LF);
      // nul before the W digits fails the line, within them it ends the number
      put_text("V:1");
      put_byte(CH_NUL);
      put_text(",W:2");
      put_byte(CH_LF);
      put_text("V:3,W:-45");
      put_byte(CH_NUL);
      put_text("9x");
      put_byte(CH_LF);
      flush_line();
   endtask

   task automatic test_saturation();
      set_idling(0, 48);
      put_text("V:99999,W:-99999");
      put_byte(CH_LF);
      put_text("V:-32769,W:32768");
      put_byte(CH_CR);
      put_text("V:00000000012,W:7");
      put_byte(CH_LF);
      flush_line();
   endtask

   task automatic test_overlong_line();
      set_idling(48, 0);
      // 62 bytes still fit
      put_text("V:1,W:2");
      repeat (55) put_byte("x");
      put_byte(CH_LF);
      // the 63rd byte restarts the line, the terminator then finds it empty
      put_text("V:1,W:2");
      repeat (56) put_byte("x");
      put_byte(CH_LF);
      // after the restart a new command parses from scratch
      repeat (63) put_byte("y");
      put_text("V:5,W:6");
      put_byte(CH_CR);
      flush_line();
   endtask

   task automatic test_random_traffic();
      int start, kind, pos;
      start = bytes_accepted;
      while (bytes_accepted - start < RANDOM_BYTES) begin
         case (((bytes_accepted - start) / 100) % 4)
            0: set_idling(0, 0);
            1: set_idling(48, 0);
            2: set_idling(0, 48);
            default: set_idling(14, 14);
         endcase
         kind = $urandom_range(99);
         if (kind < 70) begin
            put_command();
            if ($urandom_range(3) == 0)
               repeat ($urandom_range(1, 5)) put_byte(junk_byte());
         end else if (kind < 80) begin
            put_command();
            pos = $urandom_range(line_buf.size() - 1);
            line_buf[pos] = byte_type'($urandom_range(255));
         end else if (kind < 88) begin
            repeat ($urandom_range(1, 20)) put_byte(byte_type'($urandom_range(255)));
         end else if (kind < 93) begin
            put_command();
            line_buf.insert($urandom_range(line_buf.size()), CH_NUL);
         end else if (kind < 97) begin
            case ($urandom_range(2))
               0: put_text("V:-,W:3");
               1: put_text("V:+8,W:+");
               default: put_text("V:5,X:1");
            endcase
         end else begin
            put_command();
            repeat ($urandom_range(40, 70)) put_byte(junk_byte());
            if ($urandom_range(1) == 0)
               put_command();
         end
         put_terminator();
         flush_line();
      end
   endtask

   initial begin
      restart_command();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_good_lines();
      test_rejected_lines();
      test_saturation();
      test_overlong_line();
      test_random_traffic();

      req_tvalid <= 1'b0;
      set_idling(0, 0);
      for (int i = 0; i < 4000 && speed_queue.size() != 0; i++)
         @(posedge clock);
      repeat (10) @(posedge clock);
      while (speed_queue.size() != 0) begin
         report_mismatch("expected result never arrived");
         void'(speed_queue.pop_front());
      end
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/vcl_pkg.sv
rtl/vcl_parser.sv
rtl/vcl_result.sv
rtl/velocity_command_line_parser.sv
bench/testbench.sv
